FILE: rtl/bmrf_pkg.sv
package bmrf_pkg;

   // Fixed field widths of the request, result and register channels
   localparam int POS_W      = 8;
   localparam int SIZE_W     = 9;
   localparam int SUM_W      = 10;
   localparam int COL_W      = 11;
   localparam int CFG_W      = 9;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Reciprocal scaling for the divide-by-word-width multipliers
   localparam int RECIP_SHIFT = 20;

   // Register reset value for both map sizes
   localparam logic [CFG_W-1:0] MAP_SIZE_RESET = 9'd256;

   // Operation codes
   localparam logic OP_MARK = 1'b0;
   localparam logic OP_TEST = 1'b1;

   // Register select (byte address bit 2)
   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
   } map_cfg_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOAD   = 6'b000100,
      ST_SETUP  = 6'b001000,
      ST_READ   = 6'b010000,
      ST_MODIFY = 6'b100000
   } seq_state_type;

endpackage

FILE: rtl/bmrf_mem.sv
module bmrf_mem #(
   parameter int WORD_BITS = 32,
   parameter int DEPTH     = 2048,
   parameter int ADDR_W    = 11
) (
   input  logic                 clock,
   input  logic                 mem_we,
   input  logic [ADDR_W-1:0]    mem_addr,
   input  logic [WORD_BITS-1:0] mem_wdata,
   output logic [WORD_BITS-1:0] mem_rdata
);

   logic [WORD_BITS-1:0] store [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   // Single port: write when enabled, always read into the output register
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= mem_wdata;
      end
      rdata_ff <= store[mem_addr];
   end

   assign mem_rdata = rdata_ff;

endmodule

FILE: rtl/bmrf_mask.sv
module bmrf_mask #(
   parameter int WORD_BITS = 32,
   parameter int OFF_W     = 5
) (
   input  logic [OFF_W-1:0]     lo,
   input  logic [OFF_W:0]       hi,
   output logic [WORD_BITS-1:0] mask
);

   // Set bits lo up to but not including hi
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         mask[i] = ((OFF_W+1)'(i) >= {1'b0, lo}) && ((OFF_W+1)'(i) < hi);
      end
   end

endmodule

FILE: rtl/bmrf_seq.sv
module bmrf_seq #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int WORD_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bmrf_pkg::map_cfg_type                map_cfg,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic [bmrf_pkg::POS_W-1:0]           req_pos_x,
   input  logic [bmrf_pkg::POS_W-1:0]           req_pos_y,
   input  logic [bmrf_pkg::SIZE_W-1:0]          req_rect_width,
   input  logic [bmrf_pkg::SIZE_W-1:0]          req_rect_height,
   output logic                                 rsp_valid,
   output logic                                 rsp_bit_is_set,
   output logic                                 rsp_out_of_range,
   output logic                                 mem_we,
   output logic [((((MAX_WIDTH + WORD_BITS - 1) / WORD_BITS) * MAX_HEIGHT) > 1 ?
                  $clog2(((MAX_WIDTH + WORD_BITS - 1) / WORD_BITS) * MAX_HEIGHT) :
                  1)-1:0]                       mem_addr,
   output logic [WORD_BITS-1:0]                 mem_wdata,
   input  logic [WORD_BITS-1:0]                 mem_rdata
);

   localparam int POS_W  = bmrf_pkg::POS_W;
   localparam int SUM_W  = bmrf_pkg::SUM_W;
   localparam int COL_W  = bmrf_pkg::COL_W;
   localparam int ROW_WORDS_MAX = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
   localparam int STORE_DEPTH   = ROW_WORDS_MAX * MAX_HEIGHT;
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int RW_W   = $clog2(ROW_WORDS_MAX + 1);
   localparam int QW     = $clog2(((2 ** POS_W) - 1) / WORD_BITS + 1);
   localparam int WI_W   = (RW_W > QW) ? RW_W : QW;
   localparam int OFF_W  = $clog2(WORD_BITS);
   localparam int RECIP  = ((1 << bmrf_pkg::RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W = SUM_W + $clog2(RECIP + 1);

   bmrf_pkg::seq_state_type state_ff, state_in;

   logic                    op_ff, op_in;
   logic [POS_W-1:0]        px_ff, px_in;
   logic [POS_W-1:0]        py_ff, py_in;
   logic [bmrf_pkg::SIZE_W-1:0] rw_ff, rw_in;
   logic [bmrf_pkg::SIZE_W-1:0] rh_ff, rh_in;
   logic [SUM_W-1:0]        eff_w_ff, eff_w_in;
   logic [SUM_W-1:0]        eff_h_ff, eff_h_in;
   logic [RW_W-1:0]         row_words_ff, row_words_in;
   logic [QW-1:0]           q_ff, q_in;
   logic [OFF_W-1:0]        rem_ff, rem_in;
   logic [COL_W-1:0]        col0_ff, col0_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [SUM_W-1:0]        x1_ff, x1_in;
   logic [SUM_W-1:0]        y1_ff, y1_in;
   logic [POS_W-1:0]        y_ff, y_in;
   logic [WI_W-1:0]         wi_ff, wi_in;
   logic [ADDR_W-1:0]       row_base_ff, row_base_in;
   logic                    first_ff, first_in;
   logic                    oor_ff, oor_in;
   logic [ADDR_W-1:0]       clear_ff, clear_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_bit_ff, rsp_bit_in;
   logic                    rsp_oor_ff, rsp_oor_in;

   // Working signals of the shared address / column unit
   logic [SUM_W-1:0]        eff_w_c;
   logic [SUM_W-1:0]        eff_h_c;
   logic [PROD_W-1:0]       rw_prod;
   logic [PROD_W-1:0]       q_prod;
   logic [POS_W+RW_W-1:0]   rb_prod;
   logic [COL_W-1:0]        col0_c;
   logic [SUM_W-1:0]        x_end;
   logic [SUM_W-1:0]        y_end;
   logic                    mark_oor;
   logic                    test_oor;
   logic [COL_W-1:0]        col_next;
   logic                    row_end;
   logic [OFF_W-1:0]        mask_lo;
   logic [OFF_W:0]          mask_hi;
   logic [WORD_BITS-1:0]    mask;

   bmrf_mask #(
      .WORD_BITS (WORD_BITS),
      .OFF_W     (OFF_W)
   ) u_mask (
      .lo   (mask_lo),
      .hi   (mask_hi),
      .mask (mask)
   );

   // Clip the map sizes to the storage and split coordinates into word and offset
   always_comb begin
      eff_w_c  = (int'(map_cfg.width) > MAX_WIDTH) ? SUM_W'(MAX_WIDTH) : SUM_W'(map_cfg.width);
      eff_h_c  = (int'(map_cfg.height) > MAX_HEIGHT) ? SUM_W'(MAX_HEIGHT) :
                 SUM_W'(map_cfg.height);
      rw_prod  = PROD_W'(eff_w_c + SUM_W'(WORD_BITS - 1)) * PROD_W'(RECIP);
      q_prod   = PROD_W'(px_ff) * PROD_W'(RECIP);
      rb_prod  = py_ff * row_words_ff;
      col0_c   = COL_W'(q_ff) * COL_W'(WORD_BITS);
      x_end    = SUM_W'(px_ff) + SUM_W'(rw_ff);
      y_end    = SUM_W'(py_ff) + SUM_W'(rh_ff);
      mark_oor = (x_end > eff_w_ff) || (y_end > eff_h_ff);
      test_oor = (SUM_W'(px_ff) >= eff_w_ff) || (SUM_W'(py_ff) >= eff_h_ff);
      col_next = col_ff + COL_W'(WORD_BITS);
      row_end  = col_next >= COL_W'(x1_ff);
      mask_lo  = first_ff ? rem_ff : '0;
      mask_hi  = row_end ? (OFF_W+1)'(COL_W'(x1_ff) - col_ff) : (OFF_W+1)'(WORD_BITS);
   end

   // Sequencer: next values of all registers
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rw_in        = rw_ff;
      rh_in        = rh_ff;
      eff_w_in     = eff_w_ff;
      eff_h_in     = eff_h_ff;
      row_words_in = row_words_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      col0_in      = col0_ff;
      col_in       = col_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      y_in         = y_ff;
      wi_in        = wi_ff;
      row_base_in  = row_base_ff;
      first_in     = first_ff;
      oor_in       = oor_ff;
      clear_in     = clear_ff;
      rsp_valid_in = 1'b0;
      rsp_bit_in   = rsp_bit_ff;
      rsp_oor_in   = rsp_oor_ff;

      unique case (state_ff)
         bmrf_pkg::ST_CLEAR: begin
            clear_in = clear_ff + 1'b1;
            if (clear_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = bmrf_pkg::ST_IDLE;
            end
         end
         bmrf_pkg::ST_IDLE: begin
            // Capture the request
            op_in = req_operation;
            px_in = req_pos_x;
            py_in = req_pos_y;
            rw_in = req_rect_width;
            rh_in = req_rect_height;
            if (start) begin
               state_in = bmrf_pkg::ST_LOAD;
            end
         end
         bmrf_pkg::ST_LOAD: begin
            eff_w_in     = eff_w_c;
            eff_h_in     = eff_h_c;
            row_words_in = RW_W'(rw_prod >> bmrf_pkg::RECIP_SHIFT);
            q_in         = QW'(q_prod >> bmrf_pkg::RECIP_SHIFT);
            state_in     = bmrf_pkg::ST_SETUP;
         end
         bmrf_pkg::ST_SETUP: begin
            rem_in      = OFF_W'(COL_W'(px_ff) - col0_c);
            col0_in     = col0_c;
            col_in      = col0_c;
            wi_in       = WI_W'(q_ff);
            first_in    = 1'b1;
            row_base_in = ADDR_W'(rb_prod);
            y_in        = py_ff;
            x1_in       = (x_end > eff_w_ff) ? eff_w_ff : x_end;
            y1_in       = (y_end > eff_h_ff) ? eff_h_ff : y_end;
            oor_in      = mark_oor;
            if (op_ff == bmrf_pkg::OP_TEST) begin
               if (test_oor) begin
                  rsp_valid_in = 1'b1;
                  rsp_bit_in   = 1'b0;
                  rsp_oor_in   = 1'b1;
                  state_in     = bmrf_pkg::ST_IDLE;
               end else begin
                  state_in = bmrf_pkg::ST_READ;
               end
            end else if (rw_ff == '0 || rh_ff == '0) begin
               // Empty rectangle: nothing to set
               rsp_valid_in = 1'b1;
               rsp_bit_in   = 1'b0;
               rsp_oor_in   = 1'b0;
               state_in     = bmrf_pkg::ST_IDLE;
            end else if (SUM_W'(px_ff) < x1_in && SUM_W'(py_ff) < y1_in) begin
               state_in = bmrf_pkg::ST_READ;
            end else begin
               // Rectangle clipped away completely
               rsp_valid_in = 1'b1;
               rsp_bit_in   = 1'b0;
               rsp_oor_in   = mark_oor;
               state_in     = bmrf_pkg::ST_IDLE;
            end
         end
         bmrf_pkg::ST_READ: begin
            state_in = bmrf_pkg::ST_MODIFY;
         end
         bmrf_pkg::ST_MODIFY: begin
            if (op_ff == bmrf_pkg::OP_TEST) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = mem_rdata[rem_ff];
               rsp_oor_in   = 1'b0;
               state_in     = bmrf_pkg::ST_IDLE;
            end else if (!row_end) begin
               // Advance to the next word of this row
               wi_in    = wi_ff + 1'b1;
               col_in   = col_next;
               first_in = 1'b0;
               state_in = bmrf_pkg::ST_READ;
            end else if (SUM_W'(y_ff) + 1'b1 >= y1_ff) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = 1'b0;
               rsp_oor_in   = oor_ff;
               state_in     = bmrf_pkg::ST_IDLE;
            end else begin
               // Advance to the first word of the next row
               y_in        = y_ff + 1'b1;
               row_base_in = row_base_ff + ADDR_W'(row_words_ff);
               wi_in       = WI_W'(q_ff);
               col_in      = col0_ff;
               first_in    = 1'b1;
               state_in    = bmrf_pkg::ST_READ;
            end
         end
         default: begin
            state_in = bmrf_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmrf_pkg::ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      rw_ff        <= rw_in;
      rh_ff        <= rh_in;
      eff_w_ff     <= eff_w_in;
      eff_h_ff     <= eff_h_in;
      row_words_ff <= row_words_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      col0_ff      <= col0_in;
      col_ff       <= col_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      y_ff         <= y_in;
      wi_ff        <= wi_in;
      row_base_ff  <= row_base_in;
      first_ff     <= first_in;
      oor_ff       <= oor_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   // Memory port: clearing pass, then a read (test) or read-modify-write (mark) of one word
   always_comb begin
      mem_we    = (state_ff == bmrf_pkg::ST_CLEAR) ||
                  (state_ff == bmrf_pkg::ST_MODIFY && op_ff == bmrf_pkg::OP_MARK);
      mem_addr  = (state_ff == bmrf_pkg::ST_CLEAR) ? clear_ff :
                  row_base_ff + ADDR_W'(wi_ff);
      mem_wdata = (state_ff == bmrf_pkg::ST_CLEAR) ? '0 : (mem_rdata | mask);
   end

   assign busy             = (state_ff != bmrf_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bit_is_set   = rsp_bit_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // Result strobe only follows a finished request
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == bmrf_pkg::ST_IDLE)
      else $error("result strobe while sequencer busy");

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == bmrf_pkg::ST_IDLE) |=> state_ff == bmrf_pkg::ST_LOAD)
      else $error("accepted request did not start the sequencer");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == bmrf_pkg::ST_CLEAR ||
                  (state_ff == bmrf_pkg::ST_MODIFY && op_ff == bmrf_pkg::OP_MARK)))
      else $error("store written outside clear or mark");

   a_modify_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmrf_pkg::ST_MODIFY |-> $past(state_ff) == bmrf_pkg::ST_READ)
      else $error("modify step without a preceding read");

   a_bit_not_oor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bit_ff) |-> !rsp_oor_ff)
      else $error("set bit reported together with out of range");

endmodule

FILE: rtl/bit_matrix_rect_fill.sv
// Two-dimensional bit matrix: marks rectangles and tests single bits.
//
// Request channel: drive start high with req_* for one request; it is taken
// at the rising edge where start is high and busy is low. req_operation
// selects a rectangle mark or a single-bit test.
// Result channel: rsp_valid is high for exactly one cycle per request with
// rsp_bit_is_set and rsp_out_of_range; the receiver cannot stall it.
// Registers: map_width at byte address 0, map_height at 4 (APB, always
// ready); write them only while busy is low and no result is pending.
// Structure: one read-modify-write sequencer over a single-port word store.
// A test in the map runs load, setup, read and modify; a test outside the
// map or an empty or fully clipped rectangle ends after load and setup; a
// rectangle adds a read and a modify per word of each clipped row. The
// result strobe comes in the cycle where busy falls; a new request may be
// taken in that cycle. Reset: a clearing pass writes zero to all
// MAX_HEIGHT * ceil(MAX_WIDTH / WORD_BITS) store words (2048 by default),
// one per cycle, with busy high; register writes are taken during it.
module bit_matrix_rect_fill #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int WORD_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic [bmrf_pkg::POS_W-1:0]           req_pos_x,
   input  logic [bmrf_pkg::POS_W-1:0]           req_pos_y,
   input  logic [bmrf_pkg::SIZE_W-1:0]          req_rect_width,
   input  logic [bmrf_pkg::SIZE_W-1:0]          req_rect_height,
   output logic                                 rsp_valid,
   output logic                                 rsp_bit_is_set,
   output logic                                 rsp_out_of_range,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [bmrf_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [bmrf_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [bmrf_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int ROW_WORDS_MAX = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
   localparam int STORE_DEPTH   = ROW_WORDS_MAX * MAX_HEIGHT;
   localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [bmrf_pkg::CFG_W-1:0] map_width_ff, map_width_in;
   logic [bmrf_pkg::CFG_W-1:0] map_height_ff, map_height_in;
   logic                       csr_write;
   bmrf_pkg::map_cfg_type      map_cfg;

   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_addr;
   logic [WORD_BITS-1:0]       mem_wdata;
   logic [WORD_BITS-1:0]       mem_rdata;

   // Register writes
   always_comb begin
      csr_write     = psel && penable && pwrite;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            bmrf_pkg::REG_MAP_WIDTH:  map_width_in  = pwdata[bmrf_pkg::CFG_W-1:0];
            bmrf_pkg::REG_MAP_HEIGHT: map_height_in = pwdata[bmrf_pkg::CFG_W-1:0];
            default:                  map_width_in  = map_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= bmrf_pkg::MAP_SIZE_RESET;
         map_height_ff <= bmrf_pkg::MAP_SIZE_RESET;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // Register reads
   assign prdata = (paddr[2] == bmrf_pkg::REG_MAP_HEIGHT) ?
                   bmrf_pkg::CSR_DATA_W'(map_height_ff) :
                   bmrf_pkg::CSR_DATA_W'(map_width_ff);
   assign pready = 1'b1;

   assign map_cfg.width  = map_width_ff;
   assign map_cfg.height = map_height_ff;

   bmrf_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WORD_BITS  (WORD_BITS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .map_cfg          (map_cfg),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .rsp_valid        (rsp_valid),
      .rsp_bit_is_set   (rsp_bit_is_set),
      .rsp_out_of_range (rsp_out_of_range),
      .mem_we           (mem_we),
      .mem_addr         (mem_addr),
      .mem_wdata        (mem_wdata),
      .mem_rdata        (mem_rdata)
   );

   bmrf_mem #(
      .WORD_BITS (WORD_BITS),
      .DEPTH     (STORE_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule
